/* hdl/matrix_inverse_3x3_defines.svh */
// Assertion macros for the 3x3 matrix inverse block.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef MATRIX_INVERSE_3X3_DEFINES_SVH
`define MATRIX_INVERSE_3X3_DEFINES_SVH

// Same-cycle implication, off during reset
`define MI3_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("matrix_inverse_3x3 check failed");

// Next-cycle implication, off during reset
`define MI3_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("matrix_inverse_3x3 check failed");

`endif

/* hdl/mi3_pkg.sv */
// Package for the 3x3 matrix inverse: element format, item structs, constants.
// No dependencies.
`default_nettype none
package mi3_pkg;
  localparam int unsigned ElemW = 16;
  localparam int unsigned FracW = 12;

  typedef logic signed [ElemW-1:0] elem_t;

  typedef struct packed {
    elem_t a_r0c0;
    elem_t a_r0c1;
    elem_t a_r0c2;
    elem_t a_r1c0;
    elem_t a_r1c1;
    elem_t a_r1c2;
    elem_t a_r2c0;
    elem_t a_r2c1;
    elem_t a_r2c2;
  } in_item_t;

  typedef struct packed {
    elem_t b_r0c0;
    elem_t b_r0c1;
    elem_t b_r0c2;
    elem_t b_r1c0;
    elem_t b_r1c1;
    elem_t b_r1c2;
    elem_t b_r2c0;
    elem_t b_r2c1;
    elem_t b_r2c2;
    logic  det_was_zero;
    logic  any_saturated;
  } out_item_t;
endpackage
`default_nettype wire

/* hdl/matrix_inverse_3x3.sv */
// 3x3 matrix inverse by adjugate over determinant, fully pipelined.
// Depends on mi3_pkg and matrix_inverse_3x3_defines.svh.
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries one whole Q4.12 matrix per
//   item; output channel out_valid_o/out_ready_i carries the Q4.12 inverse,
//   a zero-determinant flag and a saturation flag.
//   The item passes 23 registers: input register, cofactor products,
//   cofactors, determinant products, determinant sum, range precheck,
//   one quotient bit per stage for 16 stages, output.
//   Throughput: one item per cycle while out_ready_i is high; the depth of
//   the restoring divider (one quotient bit per stage, nine lanes) sets
//   the latency.
//   A zero determinant is replaced by 68719 units of 2^-36 and flagged.
//   Results beyond 16 bits clamp to the signed limits and are flagged.
//   Reset clears all stage valid bits; the pipeline comes up empty.
//   On a receiver stall each stage holds only when the stage after it is
//   full, so bubbles close up and the block keeps taking items until every
//   stage holds an item.
`default_nettype none
`include "matrix_inverse_3x3_defines.svh"
module matrix_inverse_3x3
  import mi3_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);
  localparam int unsigned W   = ElemW;
  localparam int unsigned PW  = 2 * W;
  localparam int unsigned CW  = 2 * W + 1;
  localparam int unsigned TW  = 3 * W + 1;
  localparam int unsigned SW  = 3 * W + 3;
  localparam int unsigned DW  = 3 * W + 2;
  localparam int unsigned NW  = 2 * W + 2 * FracW;
  localparam int unsigned RW0 = (NW > DW + W) ? NW : DW + W;
  localparam int unsigned RW  = RW0 + 1;
  localparam int unsigned EW  = 3 * FracW + 21;
  localparam logic [EW-1:0] EpsBig =
    ((EW'(1) << (3 * FracW)) + EW'(500000)) / EW'(1000000);
  localparam logic [DW-1:0] EpsUnits = DW'(EpsBig);
  localparam int unsigned DivBase = 5;
  localparam int unsigned NS  = DivBase + W + 2;
  localparam logic [W-1:0] MagMax = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MagMin = {1'b1, {(W-1){1'b0}}};

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Stage 0: capture the matrix
  elem_t m_q [9];
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      m_q[0] <= in_item_i.a_r0c0;
      m_q[1] <= in_item_i.a_r0c1;
      m_q[2] <= in_item_i.a_r0c2;
      m_q[3] <= in_item_i.a_r1c0;
      m_q[4] <= in_item_i.a_r1c1;
      m_q[5] <= in_item_i.a_r1c2;
      m_q[6] <= in_item_i.a_r2c0;
      m_q[7] <= in_item_i.a_r2c1;
      m_q[8] <= in_item_i.a_r2c2;
    end
  end

  // Stage 1: two products per cofactor
  logic signed [PW-1:0] p_d [18];
  logic signed [PW-1:0] p_q [18];
  elem_t row1_q [3];
  always_comb begin
    p_d[0]  = m_q[4] * m_q[8];  p_d[1]  = m_q[5] * m_q[7];
    p_d[2]  = m_q[2] * m_q[7];  p_d[3]  = m_q[1] * m_q[8];
    p_d[4]  = m_q[1] * m_q[5];  p_d[5]  = m_q[2] * m_q[4];
    p_d[6]  = m_q[5] * m_q[6];  p_d[7]  = m_q[3] * m_q[8];
    p_d[8]  = m_q[0] * m_q[8];  p_d[9]  = m_q[2] * m_q[6];
    p_d[10] = m_q[2] * m_q[3];  p_d[11] = m_q[0] * m_q[5];
    p_d[12] = m_q[3] * m_q[7];  p_d[13] = m_q[4] * m_q[6];
    p_d[14] = m_q[1] * m_q[6];  p_d[15] = m_q[0] * m_q[7];
    p_d[16] = m_q[0] * m_q[4];  p_d[17] = m_q[1] * m_q[3];
  end
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      p_q    <= p_d;
      row1_q <= m_q[0:2];
    end
  end

  // Stage 2: cofactors
  logic signed [CW-1:0] cof_q [9];
  elem_t row2_q [3];
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int k = 0; k < 9; k++) begin
        cof_q[k] <= CW'(p_q[2*k]) - CW'(p_q[2*k+1]);
      end
      row2_q <= row1_q;
    end
  end

  // Stage 3: determinant terms along row 0
  logic signed [TW-1:0] dt_q [3];
  logic signed [CW-1:0] cof3_q [9];
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      dt_q[0] <= row2_q[0] * cof_q[0];
      dt_q[1] <= row2_q[1] * cof_q[3];
      dt_q[2] <= row2_q[2] * cof_q[6];
      cof3_q  <= cof_q;
    end
  end

  // Stage 4: determinant sum, magnitudes and signs
  logic signed [SW-1:0] det_s;
  logic [SW-1:0]        det_abs;
  logic [CW-1:0]        cof_abs [9];
  logic [DW-1:0]        den4_q;
  logic                 dz4_q;
  logic [NW-1:0]        num4_q [9];
  logic                 neg4_q [9];
  always_comb begin
    det_s   = SW'(dt_q[0]) + SW'(dt_q[1]) + SW'(dt_q[2]);
    det_abs = det_s[SW-1] ? (~det_s + SW'(1)) : det_s;
    for (int k = 0; k < 9; k++) begin
      cof_abs[k] = cof3_q[k][CW-1] ? (~cof3_q[k] + CW'(1)) : cof3_q[k];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      dz4_q  <= (det_s == '0);
      den4_q <= (det_s == '0) ? EpsUnits : det_abs[DW-1:0];
      for (int k = 0; k < 9; k++) begin
        num4_q[k] <= {cof_abs[k][PW-1:0], {(2*FracW){1'b0}}};
        neg4_q[k] <= cof3_q[k][CW-1] ^ det_s[SW-1];
      end
    end
  end

  // Divider: index 0 holds the range precheck, index j holds bit W-j done
  logic [RW-1:0] rem_q [W+1][9];
  logic [W-1:0]  quo_q [W+1][9];
  logic          ovf_q [W+1][9];
  logic          neg_q [W+1][9];
  logic [DW-1:0] den_q [W+1];
  logic          dz_q  [W+1];

  always_ff @(posedge clk_i) begin
    if (en[DivBase]) begin
      den_q[0] <= den4_q;
      dz_q[0]  <= dz4_q;
      for (int k = 0; k < 9; k++) begin
        rem_q[0][k] <= RW'(num4_q[k]);
        quo_q[0][k] <= '0;
        ovf_q[0][k] <= RW'(num4_q[k]) >= (RW'(den4_q) << W);
        neg_q[0][k] <= neg4_q[k];
      end
    end
  end

  for (genvar j = 1; j <= W; j++) begin : g_div
    logic [RW-1:0] dsh;
    logic [RW:0]   trial [9];
    assign dsh = RW'(den_q[j-1]) << (W - j);
    always_comb begin
      for (int k = 0; k < 9; k++) begin
        trial[k] = {1'b0, rem_q[j-1][k]} - {1'b0, dsh};
      end
    end
    // Subtract the shifted divisor where it fits and set the quotient bit
    always_ff @(posedge clk_i) begin
      if (en[DivBase+j]) begin
        den_q[j] <= den_q[j-1];
        dz_q[j]  <= dz_q[j-1];
        for (int k = 0; k < 9; k++) begin
          rem_q[j][k] <= trial[k][RW] ? rem_q[j-1][k] : trial[k][RW-1:0];
          quo_q[j][k] <= quo_q[j-1][k] | (W'(!trial[k][RW]) << (W - j));
          ovf_q[j][k] <= ovf_q[j-1][k];
          neg_q[j][k] <= neg_q[j-1][k];
        end
      end
    end
  end

  // Output stage: sign, saturation, flags
  elem_t res_d [9];
  logic  sat_d [9];
  logic  any_sat_d;
  always_comb begin
    any_sat_d = 1'b0;
    for (int k = 0; k < 9; k++) begin
      if (neg_q[W][k]) begin
        sat_d[k] = ovf_q[W][k] || (quo_q[W][k] > MagMin);
        res_d[k] = sat_d[k] ? elem_t'(MagMin) : elem_t'(~quo_q[W][k] + W'(1));
      end else begin
        sat_d[k] = ovf_q[W][k] || quo_q[W][k][W-1];
        res_d[k] = sat_d[k] ? elem_t'(MagMax) : elem_t'(quo_q[W][k]);
      end
      any_sat_d = any_sat_d | sat_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      out_item_o.b_r0c0        <= res_d[0];
      out_item_o.b_r0c1        <= res_d[1];
      out_item_o.b_r0c2        <= res_d[2];
      out_item_o.b_r1c0        <= res_d[3];
      out_item_o.b_r1c1        <= res_d[4];
      out_item_o.b_r1c2        <= res_d[5];
      out_item_o.b_r2c0        <= res_d[6];
      out_item_o.b_r2c1        <= res_d[7];
      out_item_o.b_r2c2        <= res_d[8];
      out_item_o.det_was_zero  <= dz_q[W];
      out_item_o.any_saturated <= any_sat_d;
    end
  end

  // Input backs up only when every stage is full and the output stalls
  `MI3_ASSERT_IMP(a_full_on_block, !in_ready_o, (&v_q) && !out_ready_i)
  // A held output item stays valid through the stall
  `MI3_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  // An empty output stage never blocks the input
  `MI3_ASSERT_IMP(a_empty_ready, !v_q[NS-1], in_ready_o)

endmodule
`default_nettype wire
